FILE: sv/hre_pkg.sv
package hre_pkg;

   // Operation codes on the request channel.
   localparam logic OP_HEADER = 1'b0;
   localparam logic OP_DATA   = 1'b1;

   localparam int CHAR_W = 7;

   localparam logic [CHAR_W-1:0] CHAR_COLON = 7'h3A;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 7'h0D;
   localparam logic [CHAR_W-1:0] CHAR_LF    = 7'h0A;

   // Index of the last hex digit for each kind of job, counting down to zero.
   localparam logic [2:0] HEADER_LAST_DIGIT = 3'd7;
   localparam logic [2:0] DATA_LAST_DIGIT   = 3'd1;

   typedef enum logic {
      JOB_HEADER,
      JOB_DATA
   } job_kind_type;

   // One classified request, ready for the character sequencer.
   typedef struct packed {
      job_kind_type kind;
      logic [31:0]  digits;
      logic         close;
      logic [7:0]   checksum;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } q_write_type;

   typedef struct packed {
      logic    avail;
      job_type job;
   } q_head_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COLON,
      ST_DIGIT,
      ST_CSUM_HI,
      ST_CSUM_LO,
      ST_CR,
      ST_LF
   } back_state_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nibble);
      logic [CHAR_W-1:0] wide;
      wide = {3'b000, nibble};
      if (nibble < 4'd10) begin
         return wide + 7'h30;
      end
      return wide + 7'h37;
   endfunction

endpackage

FILE: sv/hre_channels.sv
interface hre_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [7:0]  record_type;
   logic [15:0] load_address;
   logic [7:0]  byte_count;
   logic [7:0]  data_byte;

   modport source (
      output valid, operation, record_type, load_address, byte_count, data_byte,
      input  ready
   );
   modport sink (
      input  valid, operation, record_type, load_address, byte_count, data_byte,
      output ready
   );
endinterface

interface hre_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] character;
   logic       run_last;
   logic       record_end;

   modport source (
      output valid, character, run_last, record_end,
      input  ready
   );
   modport sink (
      input  valid, character, run_last, record_end,
      output ready
   );
endinterface

FILE: sv/hre_front.sv
module hre_front import hre_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hre_req_if.sink     req_ch,
   input  logic        queue_full,
   output q_write_type q_write
);

   logic       open_ff, open_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] sum_ff, sum_in;
   logic       accept;
   logic [7:0] hdr_sum;
   logic [7:0] data_sum;
   logic [7:0] data_left;

   assign req_ch.ready = !queue_full;
   assign accept = req_ch.valid && !queue_full;

   always_comb begin
      hdr_sum = req_ch.byte_count + req_ch.load_address[15:8]
              + req_ch.load_address[7:0] + req_ch.record_type;
      data_sum  = sum_ff + req_ch.data_byte;
      data_left = left_ff - 8'd1;

      open_in = open_ff;
      left_in = left_ff;
      sum_in  = sum_ff;

      q_write.push         = 1'b0;
      q_write.job.kind     = JOB_HEADER;
      q_write.job.digits   = '0;
      q_write.job.close    = 1'b0;
      q_write.job.checksum = '0;

      if (accept) begin
         if (req_ch.operation == OP_HEADER) begin
            // A header always starts a fresh record, abandoning any open one.
            q_write.push         = 1'b1;
            q_write.job.kind     = JOB_HEADER;
            q_write.job.digits   = {req_ch.byte_count, req_ch.load_address,
                                    req_ch.record_type};
            q_write.job.close    = (req_ch.byte_count == 8'd0);
            q_write.job.checksum = 8'd0 - hdr_sum;
            open_in = (req_ch.byte_count != 8'd0);
            left_in = req_ch.byte_count;
            sum_in  = (req_ch.byte_count == 8'd0) ? 8'd0 : hdr_sum;
         end else if (open_ff) begin
            q_write.push         = 1'b1;
            q_write.job.kind     = JOB_DATA;
            q_write.job.digits   = {req_ch.data_byte, 24'd0};
            q_write.job.close    = (data_left == 8'd0);
            q_write.job.checksum = 8'd0 - data_sum;
            if (data_left == 8'd0) begin
               open_in = 1'b0;
               left_in = 8'd0;
               sum_in  = 8'd0;
            end else begin
               left_in = data_left;
               sum_in  = data_sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         left_ff <= 8'd0;
         sum_ff  <= 8'd0;
      end else begin
         open_ff <= open_in;
         left_ff <= left_in;
         sum_ff  <= sum_in;
      end
   end

endmodule

FILE: sv/hre_queue.sv
module hre_queue import hre_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  q_write_type q_write,
   input  logic        pop,
   output logic        full,
   output q_head_type  head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         entries_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] ptr);
      if (ptr == AW'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + AW'(1);
   endfunction

   assign full       = (count_ff == CW'(DEPTH));
   assign head.avail = (count_ff != '0);
   assign head.job   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = q_write.push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (q_write.push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !q_write.push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (q_write.push) begin
         entries_ff[wr_ptr_ff] <= q_write.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: sv/hre_back.sv
module hre_back import hre_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_head_type head,
   output logic       pop,
   hre_rsp_if.source  rsp_ch
);

   back_state_type    state_ff, state_in;
   logic [31:0]       shift_ff, shift_in;
   logic [2:0]        left_ff, left_in;
   logic              close_ff, close_in;
   logic [7:0]        csum_ff, csum_in;
   logic              rvalid_ff, rvalid_in;
   logic [CHAR_W-1:0] rchar_ff, rchar_in;
   logic              rlast_ff, rlast_in;
   logic              rend_ff, rend_in;

   logic              out_free;
   logic              emit;
   logic              finish;
   logic [CHAR_W-1:0] e_char;
   logic              e_last;
   logic              e_end;

   assign out_free = !rvalid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      shift_in = shift_ff;
      left_in  = left_ff;
      close_in = close_ff;
      csum_in  = csum_ff;
      pop      = 1'b0;
      emit     = 1'b0;
      finish   = 1'b0;
      e_char   = CHAR_LF;
      e_last   = 1'b0;
      e_end    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
         end
         ST_COLON: begin
            if (out_free) begin
               emit     = 1'b1;
               e_char   = CHAR_COLON;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               emit     = 1'b1;
               e_char   = hex_char(shift_ff[31:28]);
               shift_in = {shift_ff[27:0], 4'h0};
               if (left_ff == 3'd0) begin
                  if (close_ff) begin
                     state_in = ST_CSUM_HI;
                  end else begin
                     e_last = 1'b1;
                     finish = 1'b1;
                  end
               end else begin
                  left_in = left_ff - 3'd1;
               end
            end
         end
         ST_CSUM_HI: begin
            if (out_free) begin
               emit     = 1'b1;
               e_char   = hex_char(csum_ff[7:4]);
               state_in = ST_CSUM_LO;
            end
         end
         ST_CSUM_LO: begin
            if (out_free) begin
               emit     = 1'b1;
               e_char   = hex_char(csum_ff[3:0]);
               state_in = ST_CR;
            end
         end
         ST_CR: begin
            if (out_free) begin
               emit     = 1'b1;
               e_char   = CHAR_CR;
               state_in = ST_LF;
            end
         end
         ST_LF: begin
            if (out_free) begin
               emit   = 1'b1;
               e_char = CHAR_LF;
               e_last = 1'b1;
               e_end  = 1'b1;
               finish = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The next job is loaded in the same cycle as the last character of
      // the current one, so consecutive jobs run without a gap.
      if (state_ff == ST_IDLE || finish) begin
         if (head.avail) begin
            pop      = 1'b1;
            shift_in = head.job.digits;
            close_in = head.job.close;
            csum_in  = head.job.checksum;
            if (head.job.kind == JOB_HEADER) begin
               state_in = ST_COLON;
               left_in  = HEADER_LAST_DIGIT;
            end else begin
               state_in = ST_DIGIT;
               left_in  = DATA_LAST_DIGIT;
            end
         end else begin
            state_in = ST_IDLE;
         end
      end

      rvalid_in = rvalid_ff;
      rchar_in  = rchar_ff;
      rlast_in  = rlast_ff;
      rend_in   = rend_ff;
      if (emit) begin
         rvalid_in = 1'b1;
         rchar_in  = e_char;
         rlast_in  = e_last;
         rend_in   = e_end;
      end else if (rsp_ch.ready) begin
         rvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      left_ff  <= left_in;
      close_ff <= close_in;
      csum_ff  <= csum_in;
      rchar_ff <= rchar_in;
      rlast_ff <= rlast_in;
      rend_ff  <= rend_in;
   end

   assign rsp_ch.valid      = rvalid_ff;
   assign rsp_ch.character  = rchar_ff;
   assign rsp_ch.run_last   = rlast_ff;
   assign rsp_ch.record_end = rend_ff;

endmodule

FILE: sv/hex_record_encoder_top.sv
// When the encoder is idle, the first character of an accepted request passes the job
// queue, the back end state register and the output register; earlier output delays it.
// Throughput: the output register passes one character per cycle while the receiver
// is ready; a data byte is 2 characters, a header 9, a close 4 more, an empty record 13.
// Reset is synchronous and active high; it empties the queue and closes any record.
module hex_record_encoder_top import hre_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   hre_req_if.sink   req_ch,
   hre_rsp_if.source rsp_ch
);

   // The front end accepts requests, tracks the open record (remaining byte
   // count and running sum), drops data bytes that arrive with no record open,
   // and turns each remaining request into a job that carries its hex digits
   // and, when the record closes, the finished checksum.
   q_write_type q_write;
   logic        queue_full;
   q_head_type  head;
   logic        pop;

   hre_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .q_write    (q_write)
   );

   // A short job queue lets the front end keep taking requests while the
   // back end is still spelling out characters of earlier ones.
   hre_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_write (q_write),
      .pop     (pop),
      .full    (queue_full),
      .head    (head)
   );

   // The back end is a character sequencer that, while its registered output
   // stage is free, emits one ASCII character per cycle into it, loading the next
   // job in the same cycle as the last character of the current one.
   hre_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

FILE: sv/hre_checker.sv
module hre_checker import hre_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAR_W-1:0] rsp_character,
   input logic              rsp_run_last,
   input logic              rsp_record_end
);

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character)
         && $stable(rsp_run_last) && $stable(rsp_record_end))
      else $error("response changed while stalled");

   // A record always ends on a line feed that also ends its request.
   a_end_is_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_end |-> rsp_character == CHAR_LF && rsp_run_last)
      else $error("record end not on a final line feed");

   // The colon starts a header and is never its last character.
   a_colon_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == CHAR_COLON |-> !rsp_run_last && !rsp_record_end)
      else $error("colon marked as last character");

   // Once a carriage return is taken, the line feed follows in the next cycle.
   a_cr_then_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_character == CHAR_CR |=>
         rsp_valid && rsp_character == CHAR_LF && rsp_record_end)
      else $error("carriage return not followed by line feed");

   // Reset empties the output stage.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind hex_record_encoder_top hre_checker u_hre_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_character  (rsp_ch.character),
   .rsp_run_last   (rsp_ch.run_last),
   .rsp_record_end (rsp_ch.record_end)
);
